FILE: hw/rtl/lfsf_pkg.sv
// Package for the largest free square finder.
// Field widths, register indexes and the control struct shared by the block's modules.
// No dependencies.
package lfsf_pkg;

  // Grid limits used as parameter defaults
  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned MAX_COLS_DEF = 1024;

  // Field widths
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned VAL_W      = 11;  // square side, also best_size
  localparam int unsigned OUT_ROW_W  = 10;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // Per-cell flags handed from the scan stage to the evaluator
  typedef struct packed {
    logic free;       // cell is free
    logic has_below;  // not in the bottom row
    logic has_right;  // not in the rightmost column
    logic last;       // top-left cell, ends the grid
    logic fwd;        // lower value was written in the cycle it was read
  } cell_flags_t;

endpackage

FILE: hw/rtl/lfsf_row_mem.sv
// Row buffer: one side value per column of the row below.
// Single write port, one read port with registered data. Uses lfsf_pkg.
module lfsf_row_mem #(
  parameter int unsigned DEPTH  = lfsf_pkg::MAX_COLS_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [lfsf_pkg::VAL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [lfsf_pkg::VAL_W-1:0] rd_data
);
  import lfsf_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/lfsf_scan.sv
// Scan stage: grid size registers, reverse raster position counters and the input register.
// Issues the row buffer read for each accepted cell. Uses lfsf_pkg.
module lfsf_scan #(
  parameter int unsigned MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int unsigned ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int unsigned COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [lfsf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lfsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            restart,
  // input cells
  input  logic                            in_valid,
  input  logic                            in_free,
  output logic                            in_ready,
  // row buffer read
  output logic                            rd_en,
  output logic [COL_W-1:0]                rd_addr,
  // held cell toward the evaluator
  output logic                            cell_valid,
  output lfsf_pkg::cell_flags_t           cell_flags,
  output logic [ROW_W-1:0]                cell_row,
  output logic [COL_W-1:0]                cell_col,
  input  logic                            cell_retire
);
  import lfsf_pkg::*;

  logic [ROW_W-1:0] row_last_r, row_last_nxt;
  logic [COL_W-1:0] col_last_r, col_last_nxt;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt;
  logic             cell_valid_r;
  cell_flags_t      cell_flags_r;
  logic [ROW_W-1:0] cell_row_r;
  logic [COL_W-1:0] cell_col_r;
  logic             accept;

  // clamp a count to 1..limit and return count minus one
  function automatic logic [31:0] last_index(input logic [CFG_DATA_W-1:0] v,
                                             input int unsigned limit);
    logic [31:0] cnt;
    cnt = 32'(v);
    if (cnt == 32'd0) begin
      cnt = 32'd1;
    end else if (cnt > 32'(limit)) begin
      cnt = 32'(limit);
    end
    return cnt - 32'd1;
  endfunction

  // register writes
  always_comb begin
    row_last_nxt = row_last_r;
    col_last_nxt = col_last_r;
    restart      = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ROW_COUNT: begin
          row_last_nxt = ROW_W'(last_index(cfg_wdata, MAX_ROWS));
          restart      = 1'b1;
        end
        REG_COLUMN_COUNT: begin
          col_last_nxt = COL_W'(last_index(cfg_wdata, MAX_COLS));
          restart      = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  assign in_ready = !cell_valid_r || cell_retire;
  assign accept   = in_valid && in_ready;

  // position counters, bottom-right to top-left
  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (restart) begin
      row_pos_nxt = row_last_nxt;
      col_pos_nxt = col_last_nxt;
    end else if (accept) begin
      if (col_pos_r != '0) begin
        col_pos_nxt = col_pos_r - 1'b1;
      end else if (row_pos_r != '0) begin
        row_pos_nxt = row_pos_r - 1'b1;
        col_pos_nxt = col_last_r;
      end else begin
        row_pos_nxt = row_last_r;
        col_pos_nxt = col_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_last_r   <= '0;
      col_last_r   <= '0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      cell_valid_r <= 1'b0;
    end else begin
      row_last_r <= row_last_nxt;
      col_last_r <= col_last_nxt;
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
      if (accept) begin
        cell_valid_r <= 1'b1;
      end else if (cell_retire) begin
        cell_valid_r <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_flags_r.free      <= in_free;
      cell_flags_r.has_below <= (row_pos_r != row_last_r);
      cell_flags_r.has_right <= (col_pos_r != col_last_r);
      cell_flags_r.last      <= (row_pos_r == '0) && (col_pos_r == '0);
      // single-column grid: the cell above is read while the one below is written
      cell_flags_r.fwd       <= cell_retire && (cell_col_r == col_pos_r);
      cell_row_r             <= row_pos_r;
      cell_col_r             <= col_pos_r;
    end
  end

  assign rd_en      = accept;
  assign rd_addr    = col_pos_r;
  assign cell_valid = cell_valid_r;
  assign cell_flags = cell_flags_r;
  assign cell_row   = cell_row_r;
  assign cell_col   = cell_col_r;

endmodule

FILE: hw/rtl/lfsf_eval.sv
// Evaluator: three-way minimum plus one, best square tracking and the result register.
// Writes the row buffer. Uses lfsf_pkg.
module lfsf_eval #(
  parameter int unsigned ROW_W = 10,
  parameter int unsigned COL_W = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  // held cell
  input  logic                                cell_valid,
  input  lfsf_pkg::cell_flags_t               cell_flags,
  input  logic [ROW_W-1:0]                    cell_row,
  input  logic [COL_W-1:0]                    cell_col,
  output logic                                cell_retire,
  // row buffer
  input  logic [lfsf_pkg::VAL_W-1:0]          rd_data,
  output logic                                wr_en,
  output logic [COL_W-1:0]                    wr_addr,
  output logic [lfsf_pkg::VAL_W-1:0]          wr_data,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lfsf_pkg::VAL_W-1:0]          out_size,
  output logic [lfsf_pkg::OUT_ROW_W-1:0]      out_row,
  output logic [lfsf_pkg::OUT_COL_W-1:0]      out_col
);
  import lfsf_pkg::*;

  logic [VAL_W-1:0] right_r, diag_r, last_v_r;
  logic [VAL_W-1:0] best_size_r, best_size_nxt;
  logic [ROW_W-1:0] best_row_r, best_row_nxt;
  logic [COL_W-1:0] best_col_r, best_col_nxt;
  logic [VAL_W-1:0] below, right, diag, m, v;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_size_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;

  // a grid-ending cell waits only while an unread result blocks the output register
  assign cell_retire = cell_valid && (!cell_flags.last || !out_valid_r || out_ready);

  // neighbor values, zero outside the grid
  always_comb begin
    below = '0;
    right = '0;
    diag  = '0;
    if (cell_flags.has_below) begin
      below = cell_flags.fwd ? last_v_r : rd_data;
    end
    if (cell_flags.has_right) begin
      right = right_r;
    end
    if (cell_flags.has_below && cell_flags.has_right) begin
      diag = diag_r;
    end
    m = below;
    if (right < m) begin
      m = right;
    end
    if (diag < m) begin
      m = diag;
    end
    v = cell_flags.free ? (m + 1'b1) : '0;
  end

  // best so far; a later equal size wins (topmost, leftmost corner)
  always_comb begin
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if ((v != '0) && (v >= best_size_r)) begin
      best_size_nxt = v;
      best_row_nxt  = cell_row;
      best_col_nxt  = cell_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      right_r     <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (cell_retire) begin
      if (cell_flags.last) begin
        right_r     <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        right_r     <= v;
        diag_r      <= below;
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  // value of the last retired cell, for the single-column bypass
  always_ff @(posedge clk) begin
    if (cell_retire) begin
      last_v_r <= v;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cell_retire && cell_flags.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_retire && cell_flags.last) begin
      out_size_r <= best_size_nxt;
      out_row_r  <= best_row_nxt;
      out_col_r  <= best_col_nxt;
    end
  end

  assign wr_en     = cell_retire;
  assign wr_addr   = cell_col;
  assign wr_data   = v;
  assign out_valid = out_valid_r;
  assign out_size  = out_size_r;
  assign out_row   = OUT_ROW_W'(out_row_r);
  assign out_col   = OUT_COL_W'(out_col_r);

endmodule

FILE: hw/rtl/largest_free_square_finder.sv
// Largest free square finder: accepts one grid cell per clock in reverse raster order
// (bottom row first, each row right to left) and, after the top-left cell, returns one
// transaction with the side of the largest all-free square and its top-left corner
// (topmost, then leftmost on ties; zeros when the grid holds no free cell). Each cell
// first sits in the input register while the row buffer is read, then goes through
// the minimum-plus-one logic into the result register, and a new cell is taken every
// cycle; the only stall is a grid end while the previous result has not been taken.
// Grid size is set through cfg_ with the block idle; a write restarts the scan.
// Depends on lfsf_pkg, lfsf_scan, lfsf_row_mem and lfsf_eval.
module largest_free_square_finder #(
  parameter int unsigned MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = lfsf_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [lfsf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [lfsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input cells
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lfsf_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] cell_free, rest zero
  // result
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lfsf_pkg::OUT_DATA_W-1:0]  out_tdata   // [10:0] best_size, [20:11] best_row,
                                                       // [30:21] best_column, [31] zero
);
  import lfsf_pkg::*;

  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic              restart;
  logic              rd_en, wr_en;
  logic [COL_W-1:0]  rd_addr, wr_addr;
  logic [VAL_W-1:0]  rd_data, wr_data;
  logic              cell_valid, cell_retire;
  cell_flags_t       cell_flags;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;
  logic [VAL_W-1:0]  out_size;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;

  lfsf_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .restart     (restart),
    .in_valid    (in_tvalid),
    .in_free     (in_tdata[0]),
    .in_ready    (in_tready),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .cell_valid  (cell_valid),
    .cell_flags  (cell_flags),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_retire (cell_retire)
  );

  lfsf_row_mem #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfsf_eval #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .cell_valid  (cell_valid),
    .cell_flags  (cell_flags),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_retire (cell_retire),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_size    (out_size),
    .out_row     (out_row),
    .out_col     (out_col)
  );

  // pack the result fields
  assign out_tdata = {1'b0, out_col, out_row, out_size};

endmodule

FILE: hw/rtl/lfsf_checker.sv
// Port-level checks for the largest free square finder, bound to the top level.
// Depends on lfsf_pkg and largest_free_square_finder.
module lfsf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lfsf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lfsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // no free square means the corner reads as zero
  a_empty_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:0] == 11'd0) |-> (out_tdata[30:11] == 20'd0))
    else $error("empty grid result carries a nonzero corner");

  // with the result register free the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no pending result");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind largest_free_square_finder lfsf_checker u_lfsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/lfsf_square_checker.sv
// Result checker for the largest free square finder testbench.
// Tracks configuration writes and accepted cells, predicts each grid's result and compares it.
// Depends on lfsf_pkg.
`timescale 1ns / 100ps

module lfsf_square_checker #(
  parameter int unsigned MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = lfsf_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lfsf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [lfsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lfsf_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] cell_free, rest zero
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lfsf_pkg::OUT_DATA_W-1:0]  out_tdata,  // [10:0] best_size, [20:11] best_row,
                                                       // [30:21] best_column, [31] zero
  output int                               fail_count,
  output int                               pending_count
);

  typedef logic [lfsf_pkg::VAL_W-1:0] side_t;

  // Same bit layout as out_tdata, lowest field last
  typedef struct packed {
    logic                             pad;
    logic [lfsf_pkg::OUT_COL_W-1:0]   col;
    logic [lfsf_pkg::OUT_ROW_W-1:0]   row;
    side_t                            size;
  } square_t;

  // Predicted state of the scan
  side_t                          rows_cfg;
  side_t                          cols_cfg;
  side_t                          lower_row [0:MAX_COLS-1];  // sides of the row below
  side_t                          right_side;
  side_t                          diag_side;
  logic [lfsf_pkg::OUT_ROW_W-1:0] scan_row;
  logic [lfsf_pkg::OUT_COL_W-1:0] scan_col;
  square_t                        best_square;
  square_t                        expected_squares [$];

  function automatic side_t clamp_count(side_t raw, int unsigned limit);
    if (raw == '0) return side_t'(1);
    if (raw > limit) return side_t'(limit);
    return raw;
  endfunction

  // Any register write, and the end of a grid, start over at the bottom-right cell
  function automatic void restart_scan();
    right_side  = '0;
    diag_side   = '0;
    scan_row    = lfsf_pkg::OUT_ROW_W'(rows_cfg - 1);
    scan_col    = lfsf_pkg::OUT_COL_W'(cols_cfg - 1);
    best_square = '0;
  endfunction

  always @(posedge clk) begin : predict
    side_t   below;
    side_t   right;
    side_t   diag;
    side_t   side;
    logic    has_below;
    logic    has_right;
    square_t got;
    square_t want;

    if (!rst_n) begin
      rows_cfg = side_t'(1);
      cols_cfg = side_t'(1);
      for (int i = 0; i < MAX_COLS; i++) lower_row[i] = '0;
      restart_scan();
      expected_squares.delete();
    end else begin
      // register writes only happen while idle
      if (cfg_wr_en) begin
        if (cfg_addr == lfsf_pkg::REG_ROW_COUNT)
          rows_cfg = clamp_count(cfg_wdata, MAX_ROWS);
        else if (cfg_addr == lfsf_pkg::REG_COLUMN_COUNT)
          cols_cfg = clamp_count(cfg_wdata, MAX_COLS);
        restart_scan();
      end

      // result transaction against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = square_t'(out_tdata);
        if (expected_squares.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: size %0d row %0d col %0d",
                     $time, got.size, got.row, got.col);
        end else begin
          want = expected_squares.pop_front();
          if (got.size !== want.size || got.row !== want.row || got.col !== want.col ||
              got.pad !== 1'b0) begin
            fail_count++;
            if (fail_count <= 10)
              $display(
                "%0t: mismatch: size/row/col expected %0d/%0d/%0d got %0d/%0d/%0d pad %0b",
                $time, want.size, want.row, want.col, got.size, got.row, got.col,
                got.pad);
          end
        end
      end

      // cell transaction: dynamic-programming step on the predicted state
      if (in_tvalid && in_tready) begin
        has_below = (int'(scan_row) + 1) < int'(rows_cfg);
        has_right = (int'(scan_col) + 1) < int'(cols_cfg);
        below = has_below ? lower_row[scan_col] : '0;
        right = has_right ? right_side : '0;
        diag  = (has_below && has_right) ? diag_side : '0;
        side  = '0;
        if (in_tdata[0]) begin
          side = below;
          if (right < side) side = right;
          if (diag < side) side = diag;
          side = side + side_t'(1);
        end
        diag_side          = below;
        lower_row[scan_col] = side;
        right_side         = side;

        // a later cell wins on an equal size: topmost, then leftmost
        if (side != '0 && side >= best_square.size) begin
          best_square.size = side;
          best_square.row  = scan_row;
          best_square.col  = scan_col;
        end

        if (scan_col == '0) begin
          if (scan_row == '0) begin
            expected_squares.push_back(best_square);
            restart_scan();
          end else begin
            scan_row = scan_row - 1'b1;
            scan_col = lfsf_pkg::OUT_COL_W'(cols_cfg - 1);
          end
        end else begin
          scan_col = scan_col - 1'b1;
        end
      end
      pending_count = expected_squares.size();
    end
  end

endmodule

FILE: tb/largest_free_square_finder_test.sv
// Testbench top for the largest free square finder: clock, reset, cell stimulus,
// result back-pressure, watchdog and verdict. Checking lives in lfsf_square_checker.
// Depends on lfsf_pkg, largest_free_square_finder and lfsf_square_checker.
`timescale 1ns / 100ps

module largest_free_square_finder_test;

  localparam int RANDOM_CELLS = 960;
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;   // cycles without any transaction
  localparam int SETTLE       = 4;      // lets the pipeline empty, plus margin

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [lfsf_pkg::CFG_IDX_W-1:0]   cfg_addr;
  logic [lfsf_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [lfsf_pkg::IN_DATA_W-1:0]   in_tdata;   // [0] cell_free, rest zero
  logic                             out_tvalid;
  logic                             out_tready;
  logic [lfsf_pkg::OUT_DATA_W-1:0]  out_tdata;  // [10:0] best_size, [20:11] best_row,
                                                // [30:21] best_column, [31] zero
  int                               fail_count;
  int                               pending_count;

  // stimulus state
  int  rows_eff = 1;
  int  cols_eff = 1;
  int  cells_sent = 0;
  int  stall_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  largest_free_square_finder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lfsf_square_checker square_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result receiver: random stalls, one long hold-off on request
  initial begin : result_sink
    int  hold_left;
    bit  hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 9);
      end
    end
  end

  // Drop valid, wait for every predicted result, then let the pipeline empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lfsf_pkg::CFG_IDX_W-1:0] idx, input int raw);
    int eff;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= raw[lfsf_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    // the port keeps the low 11 bits, then the count is clamped
    eff = raw & 32'h7FF;
    eff = (eff == 0) ? 1 : (eff > 1024) ? 1024 : eff;
    if (idx == lfsf_pkg::REG_ROW_COUNT) rows_eff = eff;
    else cols_eff = eff;
  endtask

  // One cell transaction, with random idle cycles ahead of it
  task automatic send_cell(input logic cell_free);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(lfsf_pkg::IN_DATA_W-1){1'b0}}, cell_free};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cells_sent++;
    @(negedge clk);
  endtask

  // Cells in scan order, bit 0 first
  task automatic send_pattern(input logic [15:0] cells, input int count);
    for (int i = 0; i < count; i++) send_cell(cells[i]);
  endtask

  task automatic send_random_cells(input int count, input int free_pct);
    for (int i = 0; i < count; i++) send_cell($urandom_range(99) < free_pct);
  endtask

  initial begin : stimulus
    int  r_raw;
    int  c_raw;
    int  grids;
    int  pick;
    bit  pressure_done;

    pressure_done = 1'b0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= lfsf_pkg::REG_ROW_COUNT;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 1x1 free and 1x1 obstacle (no free cell) at reset size
    send_cell(1'b1);
    send_cell(1'b0);
    // full 2x2 square
    write_reg(lfsf_pkg::REG_ROW_COUNT, 2);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 2);
    send_pattern(16'h000F, 4);
    // checkerboard 3x3: all sizes tie, top-left corner must win
    write_reg(lfsf_pkg::REG_ROW_COUNT, 3);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 3);
    send_pattern(16'h0155, 9);
    // single row, two equal candidates
    write_reg(lfsf_pkg::REG_ROW_COUNT, 1);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 4);
    send_pattern(16'h0006, 4);
    // single column
    write_reg(lfsf_pkg::REG_ROW_COUNT, 4);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 1);
    send_pattern(16'h000D, 4);

    // Random grids, mostly small, some left unfinished before a register write
    while (cells_sent < 23 + RANDOM_CELLS) begin
      gaps_on = !(cells_sent >= 600 && cells_sent < 850);

      // receiver holds off while 1x1 grids keep coming
      if (!pressure_done && cells_sent >= 400) begin
        pressure_done = 1'b1;
        write_reg(lfsf_pkg::REG_ROW_COUNT, 1);
        write_reg(lfsf_pkg::REG_COLUMN_COUNT, 1);
        hold_req = 1'b1;
        send_random_cells(40, 50);
      end

      pick  = $urandom_range(11);
      r_raw = (pick == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      c_raw = (pick == 1) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      case ($urandom_range(3))
        0: write_reg(lfsf_pkg::REG_ROW_COUNT, r_raw);
        1: write_reg(lfsf_pkg::REG_COLUMN_COUNT, c_raw);
        default: begin
          write_reg(lfsf_pkg::REG_ROW_COUNT, r_raw);
          write_reg(lfsf_pkg::REG_COLUMN_COUNT, c_raw);
        end
      endcase

      grids = $urandom_range(1, 4);
      repeat (grids) send_random_cells(rows_eff * cols_eff, $urandom_range(30, 100));
      if (rows_eff * cols_eff > 1 && $urandom_range(4) == 0)
        send_random_cells($urandom_range(1, rows_eff * cols_eff - 1), $urandom_range(30, 100));
    end
    gaps_on = 1'b1;

    // Extremes: a zero count taken as one, counts above the 11-bit port wrap
    write_reg(lfsf_pkg::REG_ROW_COUNT, 0);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 2048 + 38);
    send_random_cells(38, 97);
    write_reg(lfsf_pkg::REG_ROW_COUNT, 2048 + 20);
    write_reg(lfsf_pkg::REG_COLUMN_COUNT, 0);
    send_random_cells(20, 97);

    wait_drained();
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
